/* rtl/core/anos_pkg.sv */
// Shared types and constants for the arpeggio note order selector.
package anos_pkg;
   localparam int StepWidth  = 16;
   localparam int CountWidth = 6;
   localparam int SlotWidth  = 5;
   localparam int OrderWidth = 4;
   localparam int SlotLimit  = 32;

   typedef enum logic [OrderWidth-1:0] {
      ORDER_CHORD    = 4'd0,
      ORDER_UP       = 4'd1,
      ORDER_DOWN     = 4'd2,
      ORDER_UPDOWN   = 4'd3,
      ORDER_DOWNUP   = 4'd4,
      ORDER_UPX2     = 4'd5,
      ORDER_DOWNX2   = 4'd6,
      ORDER_UPDOWNX2 = 4'd7,
      ORDER_CONVERGE = 4'd8,
      ORDER_DIVERGE  = 4'd9,
      ORDER_THUMB    = 4'd10,
      ORDER_UPPLUS   = 4'd11
   } order_type;

   // Control word passed from the front end to the modulo unit.
   typedef struct packed {
      logic [StepWidth-1:0] dividend;
      logic [CountWidth:0]  divisor;
   } mod_req_type;
endpackage

/* rtl/core/anos_if.sv */
// Valid/ready channel interfaces for the note order selector.
interface anos_req_if;
   import anos_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [StepWidth-1:0]  step_counter;
   logic [CountWidth-1:0] held_count;
   modport source (output valid, output step_counter, output held_count, input ready);
   modport sink   (input valid, input step_counter, input held_count, output ready);
endinterface

interface anos_rsp_if;
   import anos_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [SlotWidth-1:0] note_slot;
   logic                 octave_up;
   logic                 last_of_run;
   modport source (output valid, output note_slot, output octave_up, output last_of_run,
                   input ready);
   modport sink   (input valid, input note_slot, input octave_up, input last_of_run,
                   output ready);
endinterface

interface anos_csr_if;
   import anos_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OrderWidth-1:0] order_sel;
   modport source (output valid, output order_sel, input ready);
   modport sink   (input valid, input order_sel, output ready);
endinterface

/* rtl/core/arpeggio_note_order_selector.sv */
// Top level of the arpeggio note order selector.
// Each request passes through a front register stage, a sixteen stage remainder pipeline (one
// quotient bit per stage) and mapping logic into the output register; a new request may enter
// every cycle while the output is free and no chord is playing.
// A stalled output holds the whole pipeline. Single-result orders give one transaction per
// cycle while the receiver takes them; chord mode holds the pipeline while it plays slots 0
// to n-1, one per cycle. A zero note count or an unused order code gives no result.
module arpeggio_note_order_selector
   import anos_pkg::*;
#(
   parameter int MAX_NOTES = 32
)
(
   input logic clock,
   input logic reset,
   anos_req_if.sink   req,
   anos_rsp_if.source rsp,
   anos_csr_if.sink   csr
);
   localparam int CapRaw = (MAX_NOTES < SlotLimit) ? MAX_NOTES : SlotLimit;
   localparam logic [CountWidth-1:0] Cap = CountWidth'(CapRaw);

   order_type order_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_UP;
      end else if (csr.valid && csr.ready) begin
         order_ff <= order_type'(csr.order_sel);
      end
   end
   assign csr.ready = 1'b1;

   // Output stage and chord sequencer.
   logic                  out_valid_ff;
   logic [SlotWidth-1:0]  out_slot_ff;
   logic                  out_oct_ff;
   logic                  out_last_ff;
   logic                  chord_ff;
   logic [CountWidth-1:0] chord_n_ff;
   logic [CountWidth-1:0] chord_i_ff;

   logic out_free;
   logic advance;
   assign out_free = !out_valid_ff || rsp.ready;
   assign advance  = out_free && !chord_ff;
   assign req.ready = advance;

   // Front stage: saturate count, pick divisor and dividend.
   logic                  f_valid_ff;
   logic [CountWidth-1:0] f_n_ff;
   logic [StepWidth-1:0]  f_p_ff;
   logic [CountWidth:0]   f_d_ff;
   logic                  f_valid_in;
   logic [CountWidth-1:0] n_sat;
   logic [StepWidth-1:0]  dividend;
   logic [CountWidth:0]   divisor;

   always_comb begin
      n_sat = (req.held_count > Cap) ? Cap : req.held_count;
      f_valid_in = req.valid && (n_sat != '0) && (order_ff <= ORDER_UPPLUS);
      dividend = req.step_counter;
      divisor  = {1'b0, n_sat};
      case (order_ff)
         ORDER_UPX2, ORDER_DOWNX2: dividend = req.step_counter >> 1;
         ORDER_UPDOWNX2: begin
            dividend = req.step_counter >> 1;
            divisor  = {n_sat - 1'b1, 1'b0};
         end
         ORDER_UPDOWN, ORDER_DOWNUP, ORDER_THUMB: divisor = {n_sat - 1'b1, 1'b0};
         ORDER_UPPLUS: divisor = {1'b0, n_sat} + 1'b1;
         default: ;
      endcase
      // single note: folding orders use divisor one, result zero
      if (divisor == '0) begin
         divisor = 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= f_valid_in;
      end
      if (advance) begin
         f_n_ff <= n_sat;
         f_p_ff <= dividend;
         f_d_ff <= divisor;
      end
   end

   // Carry n alongside the remainder pipeline.
   localparam int Depth = StepWidth;
   logic [CountWidth-1:0] n_pipe_ff [Depth];
   always_ff @(posedge clock) begin
      if (advance) begin
         n_pipe_ff[0] <= f_n_ff;
         for (int i = 1; i < Depth; i++) begin
            n_pipe_ff[i] <= n_pipe_ff[i-1];
         end
      end
   end

   mod_req_type         m_req;
   logic                m_valid;
   logic [CountWidth:0] m_rem;
   logic [CountWidth-1:0] m_n;
   assign m_req.dividend = f_p_ff;
   assign m_req.divisor  = f_d_ff;
   assign m_n = n_pipe_ff[Depth-1];

   anos_mod_pipe u_mod (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f_valid_ff),
      .in_req    (m_req),
      .out_valid (m_valid),
      .remainder (m_rem)
   );

   // Mapping stage.
   logic [SlotWidth-1:0] slot;
   logic                 oct;
   logic [CountWidth:0]  q;
   logic [CountWidth:0]  nm1;
   logic [CountWidth:0]  half;
   logic [CountWidth:0]  mid;
   always_comb begin
      q    = m_rem;
      nm1  = {1'b0, m_n} - 1'b1;
      half = q >> 1;
      mid  = nm1 >> 1;
      oct  = 1'b0;
      slot = '0;
      case (order_ff)
         ORDER_UP, ORDER_UPX2: slot = q[SlotWidth-1:0];
         ORDER_DOWN, ORDER_DOWNX2: slot = SlotWidth'(nm1 - q);
         ORDER_UPDOWN, ORDER_UPDOWNX2:
            slot = (q <= nm1) ? q[SlotWidth-1:0] : SlotWidth'({nm1, 1'b0} - q);
         ORDER_DOWNUP:
            slot = (q <= nm1) ? SlotWidth'(nm1 - q) : SlotWidth'(q - nm1);
         ORDER_CONVERGE: slot = q[0] ? SlotWidth'(nm1 - half) : half[SlotWidth-1:0];
         ORDER_DIVERGE:  slot = q[0] ? SlotWidth'(mid + 1'b1 + half) : SlotWidth'(mid - half);
         ORDER_THUMB:    slot = q[0] ? SlotWidth'(half + 1'b1) : '0;
         ORDER_UPPLUS: begin
            if (q[CountWidth-1:0] == m_n) begin
               slot = nm1[SlotWidth-1:0];
               oct  = 1'b1;
            end else begin
               slot = q[SlotWidth-1:0];
            end
         end
         default: slot = '0;
      endcase
      if (m_n == 6'd1 && order_ff != ORDER_UPPLUS) begin
         slot = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         chord_ff     <= 1'b0;
      end else if (chord_ff) begin
         if (out_free) begin
            // advance through the chord, one slot per transaction
            out_valid_ff <= 1'b1;
            out_slot_ff  <= chord_i_ff[SlotWidth-1:0];
            out_oct_ff   <= 1'b0;
            out_last_ff  <= (chord_i_ff + 1'b1 == chord_n_ff);
            chord_i_ff   <= chord_i_ff + 1'b1;
            chord_ff     <= (chord_i_ff + 1'b1 != chord_n_ff);
         end
      end else if (advance) begin
         if (m_valid && order_ff == ORDER_CHORD) begin
            out_valid_ff <= 1'b1;
            out_slot_ff  <= '0;
            out_oct_ff   <= 1'b0;
            out_last_ff  <= (m_n == 6'd1);
            chord_n_ff   <= m_n;
            chord_i_ff   <= 6'd1;
            chord_ff     <= (m_n != 6'd1);
         end else begin
            out_valid_ff <= m_valid;
            out_slot_ff  <= slot;
            out_oct_ff   <= oct;
            out_last_ff  <= 1'b1;
         end
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.note_slot   = out_slot_ff;
   assign rsp.octave_up   = out_oct_ff;
   assign rsp.last_of_run = out_last_ff;
endmodule

/* rtl/core/anos_mod_pipe.sv */
// Pipelined restoring remainder unit: one quotient bit per stage.
module anos_mod_pipe
   import anos_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  mod_req_type           in_req,
   output logic                  out_valid,
   output logic [CountWidth:0]   remainder
);
   localparam int Stages = StepWidth;
   localparam int RemW   = CountWidth + 2;
   localparam int DivW   = CountWidth + 1;

   logic [Stages-1:0]          valid_ff;
   logic [DivW-1:0]            rem_ff  [Stages];
   logic [StepWidth-1:0]       num_ff  [Stages-1];
   logic [DivW-1:0]            div_ff  [Stages-1];

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic                 valid_src;
      logic [DivW-1:0]      rem_src;
      logic [StepWidth-1:0] num_src;
      logic [DivW-1:0]      div_src;
      logic [RemW-1:0]      trial;
      logic [DivW-1:0]      rem_in;

      if (s == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign num_src   = in_req.dividend;
         assign div_src   = in_req.divisor;
      end else begin : g_next
         assign valid_src = valid_ff[s-1];
         assign rem_src   = rem_ff[s-1];
         assign num_src   = num_ff[s-1];
         assign div_src   = div_ff[s-1];
      end

      always_comb begin
         trial  = {rem_src, num_src[StepWidth-1-s]};
         rem_in = (trial >= {1'b0, div_src}) ? DivW'(trial - {1'b0, div_src})
                                             : trial[DivW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_src;
         end
         if (advance) begin
            rem_ff[s] <= rem_in;
         end
      end

      // the last stage keeps only its remainder and valid bit
      if (s < Stages - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               num_ff[s] <= num_src;
               div_ff[s] <= div_src;
            end
         end
      end
   end

   assign out_valid = valid_ff[Stages-1];
   assign remainder = rem_ff[Stages-1];
endmodule

/* rtl/core/anos_checker.sv */
// Port-level checker for the arpeggio note order selector, bound to the top level.
module anos_checker
   import anos_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [SlotWidth-1:0] rsp_note_slot,
   input logic                 rsp_octave_up,
   input logic                 rsp_last_of_run
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_note_slot))
      else $error("result dropped while stalled");
   a_oct_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_octave_up |-> rsp_last_of_run)
      else $error("octave result not last");
   a_chord_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=>
      rsp_valid && rsp_note_slot == $past(rsp_note_slot) + 1'b1)
      else $error("chord slots out of order");
   a_chord_oct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !rsp_octave_up)
      else $error("octave inside chord");
endmodule

bind arpeggio_note_order_selector anos_checker u_anos_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_note_slot   (rsp.note_slot),
   .rsp_octave_up   (rsp.octave_up),
   .rsp_last_of_run (rsp.last_of_run)
);

/* verif/anos_tb_if.sv */
// Testbench package: the expected result record used by the checker.
package anos_tb_pkg;
   import anos_pkg::*;
   typedef struct packed {
      logic [SlotWidth-1:0] note_slot;
      logic                 octave_up;
      logic                 last_of_run;
   } slot_pick_type;
endpackage

/* verif/anos_checker.sv */
// Checker that predicts slot selections and compares them with the block's output.
module anos_pick_checker
   import anos_pkg::*;
   import anos_tb_pkg::*;
#(
   parameter int MAX_NOTES = 32
)
(
   input  logic       clock,
   input  logic       reset,
   anos_req_if        req_mon,
   anos_rsp_if        rsp_mon,
   anos_csr_if        csr_mon,
   output int         fail_count,
   output int         pending_count,
   output int         pick_count
);
   slot_pick_type pick_q[$];
   logic [OrderWidth-1:0] cur_order;

   function automatic int fold_pos(int q, int n);
      int c;
      int pos;
      c = 2 * (n - 1);
      pos = q % c;
      return (pos < n) ? pos : c - pos;
   endfunction

   task automatic predict_picks(input int p, input int n_raw);
      int n;
      int slot;
      int oct;
      int q;
      int m;
      slot_pick_type pk;
      n = n_raw;
      if (n > MAX_NOTES) n = MAX_NOTES;
      if (n > SlotLimit) n = SlotLimit;
      if (n == 0 || cur_order > ORDER_UPPLUS) return;
      slot = 0;
      oct = 0;
      case (order_type'(cur_order))
         ORDER_CHORD: begin
            for (int i = 0; i < n; i++) begin
               pk.note_slot = i[SlotWidth-1:0];
               pk.octave_up = 1'b0;
               pk.last_of_run = (i + 1 == n);
               pick_q.push_back(pk);
            end
            return;
         end
         ORDER_UP:       slot = p % n;
         ORDER_DOWN:     slot = (n - 1) - (p % n);
         ORDER_UPDOWN:   slot = (n <= 1) ? 0 : fold_pos(p, n);
         ORDER_DOWNUP:   slot = (n <= 1) ? 0 : (n - 1) - fold_pos(p, n);
         ORDER_UPX2:     slot = (p / 2) % n;
         ORDER_DOWNX2:   slot = (n - 1) - ((p / 2) % n);
         ORDER_UPDOWNX2: slot = (n <= 1) ? 0 : fold_pos(p / 2, n);
         ORDER_CONVERGE: begin
            if (n > 1) begin
               q = p % n;
               slot = (q % 2 == 0) ? q / 2 : (n - 1) - q / 2;
            end
         end
         ORDER_DIVERGE: begin
            if (n > 1) begin
               m = (n - 1) / 2;
               q = p % n;
               slot = (q % 2 == 0) ? m - q / 2 : m + 1 + q / 2;
            end
         end
         ORDER_THUMB: begin
            if (n > 1) begin
               q = p % (2 * (n - 1));
               slot = (q % 2 == 0) ? 0 : 1 + q / 2;
            end
         end
         default: begin
            q = p % (n + 1);
            if (q < n) slot = q;
            else begin
               slot = n - 1;
               oct = 1;
            end
         end
      endcase
      pk.note_slot = slot[SlotWidth-1:0];
      pk.octave_up = oct[0];
      pk.last_of_run = 1'b1;
      pick_q.push_back(pk);
   endtask

   always @(posedge clock) begin
      slot_pick_type want;
      int errs;
      errs = 0;
      if (reset) begin
         cur_order <= ORDER_UP;
         pick_q.delete();
         fail_count <= 0;
         pick_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_picks(int'(req_mon.step_counter), int'(req_mon.held_count));
         if (csr_mon.valid && csr_mon.ready) cur_order <= csr_mon.order_sel;
         if (rsp_mon.valid && rsp_mon.ready) begin
            pick_count <= pick_count + 1;
            if (pick_q.size() == 0) begin
               $error("unexpected transaction: slot %0d", rsp_mon.note_slot);
               errs++;
            end else begin
               want = pick_q.pop_front();
               if (want.note_slot !== rsp_mon.note_slot) begin
                  $error("note_slot expected %0d actual %0d", want.note_slot,
                         rsp_mon.note_slot);
                  errs++;
               end
               if (want.octave_up !== rsp_mon.octave_up) begin
                  $error("octave_up expected %0d actual %0d", want.octave_up,
                         rsp_mon.octave_up);
                  errs++;
               end
               if (want.last_of_run !== rsp_mon.last_of_run) begin
                  $error("last_of_run expected %0d actual %0d", want.last_of_run,
                         rsp_mon.last_of_run);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending_count <= pick_q.size();
      end
   end
endmodule

/* verif/tb_arpeggio_note_order_selector.sv */
// Testbench top: stimulus, idling and verdict for the note order selector.
module tb_arpeggio_note_order_selector;
   import anos_pkg::*;

   localparam int DrainCycles = 40;
   localparam int CycleLimit  = 400000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   pick_count;
   int   cycle_count = 0;
   int   step_count;
   bit   rsp_stall_on;

   anos_req_if req_bus ();
   anos_rsp_if rsp_bus ();
   anos_csr_if csr_bus ();

   arpeggio_note_order_selector #(.MAX_NOTES(32)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source),
      .csr   (csr_bus.sink)
   );

   anos_pick_checker #(.MAX_NOTES(32)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_mon       (csr_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .pick_count    (pick_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_arpeggio_note_order_selector failed");
         $finish;
      end
   end

   // receiver stall, off during the first random phase
   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !(rsp_stall_on && $urandom_range(99) < 19);
   end

   // valid stays high after acceptance so that steps can follow back to back
   task automatic send_step(input logic [StepWidth-1:0] p, input logic [CountWidth-1:0] n,
                            input bit may_idle);
      while (may_idle && $urandom_range(99) < 19) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.step_counter <= p;
      req_bus.held_count <= n;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      step_count++;
   endtask

   task automatic write_order(input logic [OrderWidth-1:0] ord);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.order_sel <= ord;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [CountWidth-1:0] pick_count_field();
      int r;
      r = $urandom_range(99);
      if (r < 8) return CountWidth'($urandom_range(63));
      if (r < 70) return CountWidth'($urandom_range(8, 1));
      return CountWidth'($urandom_range(32, 1));
   endfunction

   initial begin
      logic [OrderWidth-1:0] ord;
      step_count = 0;
      rsp_stall_on = 1'b1;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.step_counter = '0;
      req_bus.held_count = '0;
      csr_bus.valid = 1'b0;
      csr_bus.order_sel = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset order is up: field extremes and count edge cases
      send_step(16'h0000, 6'd0, 0);
      send_step(16'hFFFF, 6'd1, 0);
      send_step(16'hFFFF, 6'd32, 0);
      send_step(16'hAAAA, 6'd63, 0);
      send_step(16'h5555, 6'd33, 0);
      send_step(16'h1234, 6'd7, 0);

      // one directed step for every order, plus unused codes
      for (int o = 0; o < 16; o++) begin
         write_order(o[OrderWidth-1:0]);
         send_step(16'($urandom_range(65535)), (o == 0) ? 6'd32 : 6'd5, 0);
         if (o == 11 || o == 3) send_step(16'd1, 6'd1, 0);
      end

      // random phases, the first with no idling on either side
      for (int ph = 0; ph < 14; ph++) begin
         rsp_stall_on = (ph != 0);
         if (ph == 1) ord = ORDER_CHORD;
         else if (ph == 2) ord = ORDER_UPPLUS;
         else if (ph == 3) ord = 4'd15;
         else ord = OrderWidth'($urandom_range(11));
         write_order(ord);
         for (int i = 0; i < 27; i++) begin
            if (ord == ORDER_CHORD && i > 8) break;
            // hold off until every result has come
            if (i == 13) begin
               req_bus.valid <= 1'b0;
               @(negedge clock);
               while (pending_count != 0) @(negedge clock);
            end
            send_step(16'($urandom_range(65535)), pick_count_field(), ph != 0);
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      $display("covered %0d steps over all twelve orders and unused codes, %0d slot picks",
               step_count, pick_count);
      if (fail_count == 0) $display("tb_arpeggio_note_order_selector passed");
      else $display("tb_arpeggio_note_order_selector failed");
      $finish;
   end
endmodule
